### rtl/core/ptw_pkg.sv
// Shared constants, operation codes and helpers of the page table walker.
package ptw_pkg;

  // Default sizing of the walker.
  localparam int LEVELS_DEF      = 2;
  localparam int TABLE_PAGES_DEF = 64;
  localparam int PAGE_SHIFT_DEF  = 12;

  // Table geometry.
  localparam int IDX_BITS     = 9;
  localparam int PAGE_ENTRIES = 512;
  localparam int PPN_W        = 44;
  localparam int ENTRY_W      = 50;
  localparam int VA_W         = 48;
  localparam int PA_W         = 56;

  // Entry flag positions; the page number sits above them.
  localparam int F_V     = 0;
  localparam int F_R     = 1;
  localparam int F_W     = 2;
  localparam int F_X     = 3;
  localparam int F_U     = 4;
  localparam int F_G     = 5;
  localparam int PPN_POS = 6;

  // Request modes.
  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_MAP       = 3'd1;
  localparam logic [2:0] MODE_UNMAP     = 3'd2;
  localparam logic [2:0] MODE_SH_MAP    = 3'd3;
  localparam logic [2:0] MODE_SH_QUERY  = 3'd4;
  localparam logic [2:0] MODE_SH_COPY   = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_STORE_BASE = 1'b0;
  localparam logic CFG_POOL_FIRST = 1'b1;

  // Index bits of one walk level taken from the virtual address.
  function automatic logic [IDX_BITS-1:0] lvl_idx(input logic [VA_W-1:0] va,
                                                  input int unsigned lv,
                                                  input int unsigned ps);
    logic [VA_W-1:0] sh;
    sh = va >> (IDX_BITS * lv + ps);
    return sh[IDX_BITS-1:0];
  endfunction

endpackage

### rtl/core/ptw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ptw_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/page_table_walk_map_unmap_unit.sv
// Top level of the page table walker: request sequencer around the entry RAM.
// Walks read and evaluate one entry per level; an unknown mode or a bad root goes
// straight to the result; each page taken from the pool is zeroed, then linked.
// Flow: one request at a time; the next is taken once the result is registered.
// Reset: synchronous; afterwards a clearing pass zeroes the entry RAM while no
// request is taken; configuration writes are taken as ever.
module page_table_walk_map_unmap_unit #(
  parameter int LEVELS      = ptw_pkg::LEVELS_DEF,
  parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF,
  parameter int PAGE_SHIFT  = ptw_pkg::PAGE_SHIFT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // root_table[5:0], source_table[11:6], vaddr[59:12],
  // paddr[115:60], allocate[116], readable[117], writable[118],
  // executable[119], user_access[120], global_map[121], zero fill above
  input  logic [127:0] s_tdata,
  // mode[2:0]
  input  logic [2:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ok[0], page_address[56:1], zero fill above
  output logic [63:0]  m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [43:0]  cfg_data
);

  localparam int DEPTH = TABLE_PAGES * ptw_pkg::PAGE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PG_W  = AW - ptw_pkg::IDX_BITS;
  localparam int LVW   = $clog2(LEVELS + 1);
  localparam int EW    = ptw_pkg::ENTRY_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WEV  = 4'd3;
  localparam logic [3:0] S_ZERO = 4'd4;
  localparam logic [3:0] S_LINK = 4'd5;
  localparam logic [3:0] S_TRD  = 4'd6;
  localparam logic [3:0] S_TEV  = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SEV  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]  state;
  logic [2:0]  mode;
  logic [ptw_pkg::VA_W-1:0] va;
  logic [ptw_pkg::PA_W-1:0] pa;
  logic        alloc;
  logic [4:0]  perm;
  logic [5:0]  root;
  logic [PG_W-1:0] new_page;
  logic [LVW-1:0]  lv;
  logic [AW-1:0]   slot;
  logic [AW-1:0]   sweep;
  logic [EW-1:0]   src_ent;
  logic        ok;
  logic [ptw_pkg::PA_W-1:0] addr;
  logic [6:0]  pages_allocated;
  logic [43:0] store_base_page;
  logic [6:0]  pool_first_page;
  logic        out_ok;
  logic [ptw_pkg::PA_W-1:0] out_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ent;

  logic [7:0]  pool_sum;
  logic        pool_ok;
  logic [43:0] diff;
  logic        diff_ok;
  logic [LVW-1:0] nlv;
  logic [EW-1:0]  link_entry;
  logic [EW-1:0]  leaf_entry;
  logic [43:0]    leaf_ppn;
  logic [43:0]    ent_ppn;
  logic [ptw_pkg::IDX_BITS-1:0] top_in;
  logic [ptw_pkg::VA_W-1:0] in_va;
  logic [5:0] in_root;
  logic [5:0] in_src;
  logic       out_free;

  // Entry RAM.
  ptw_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ent)
  );

  // Input fields and derived walk values.
  assign in_root  = s_tdata[5:0];
  assign in_src   = s_tdata[11:6];
  assign in_va    = s_tdata[59:12];
  assign top_in   = ptw_pkg::lvl_idx(in_va, LEVELS, PAGE_SHIFT);
  assign pool_sum = {1'b0, pool_first_page} + {1'b0, pages_allocated};
  assign pool_ok  = (pages_allocated != 7'h7f) && (32'(pool_sum) < TABLE_PAGES);
  assign ent_ppn  = ent[ptw_pkg::PPN_POS +: ptw_pkg::PPN_W];
  assign diff     = ent_ppn - store_base_page;
  assign diff_ok  = diff < 44'(TABLE_PAGES);
  assign nlv      = lv - 1'b1;
  assign link_entry = {store_base_page + 44'(new_page), 5'b0, 1'b1};
  assign leaf_ppn   = 44'(pa >> PAGE_SHIFT);
  assign leaf_entry = {leaf_ppn, perm, 1'b1};
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE);

  // RAM write port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '0;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {new_page, sweep[ptw_pkg::IDX_BITS-1:0]};
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = link_entry;
      end
      S_WEV: begin
        if (lv == '0) begin
          if (mode == ptw_pkg::MODE_MAP && !ent[ptw_pkg::F_V]) begin
            ram_we    = 1'b1;
            ram_wdata = leaf_entry;
          end else if (mode == ptw_pkg::MODE_UNMAP && ent[ptw_pkg::F_V]) begin
            ram_we = 1'b1;
          end
        end
      end
      S_TEV: begin
        if (mode == ptw_pkg::MODE_SH_COPY && src_ent[ptw_pkg::F_V] && !ent[ptw_pkg::F_V]) begin
          ram_we    = 1'b1;
          ram_wdata = src_ent;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      store_base_page <= '0;
      pool_first_page <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        ptw_pkg::CFG_STORE_BASE: store_base_page <= cfg_data;
        ptw_pkg::CFG_POOL_FIRST: pool_first_page <= cfg_data[6:0];
        default: store_base_page <= store_base_page;
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      sweep           <= '0;
      pages_allocated <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      // A taken result clears the output unless a new one is loaded in its place.
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            mode  <= s_tuser;
            va    <= in_va;
            pa    <= s_tdata[115:60];
            alloc <= s_tdata[116];
            perm  <= s_tdata[121:117];
            root  <= in_root;
            lv    <= LVW'(LEVELS);
            ok    <= 1'b0;
            addr  <= '0;
            case (s_tuser)
              ptw_pkg::MODE_TRANSLATE, ptw_pkg::MODE_MAP, ptw_pkg::MODE_UNMAP: begin
                if (32'(in_root) < TABLE_PAGES) begin
                  slot  <= {PG_W'(in_root), top_in};
                  state <= S_WRD;
                end else begin
                  state <= S_DONE;
                end
              end
              ptw_pkg::MODE_SH_MAP, ptw_pkg::MODE_SH_QUERY: begin
                if (32'(in_root) < TABLE_PAGES) begin
                  slot  <= {PG_W'(in_root), top_in};
                  state <= S_TRD;
                end else begin
                  state <= S_DONE;
                end
              end
              ptw_pkg::MODE_SH_COPY: begin
                if (32'(in_root) < TABLE_PAGES && 32'(in_src) < TABLE_PAGES) begin
                  slot  <= {PG_W'(in_src), top_in};
                  state <= S_SRD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_WRD: state <= S_WEV;
        S_WEV: begin
          if (lv == '0) begin
            // Leaf entry.
            state <= S_DONE;
            if (mode == ptw_pkg::MODE_TRANSLATE && ent[ptw_pkg::F_V]) begin
              ok   <= 1'b1;
              addr <= ptw_pkg::PA_W'({20'b0, ent_ppn} << PAGE_SHIFT);
            end else if (mode == ptw_pkg::MODE_MAP && !ent[ptw_pkg::F_V]) begin
              ok <= 1'b1;
            end else if (mode == ptw_pkg::MODE_UNMAP && ent[ptw_pkg::F_V]) begin
              ok <= 1'b1;
            end
          end else if (!ent[ptw_pkg::F_V]) begin
            // Missing table page: take one from the pool when allowed.
            if (mode == ptw_pkg::MODE_MAP && alloc && pool_ok) begin
              new_page        <= PG_W'(pool_sum);
              pages_allocated <= pages_allocated + 1'b1;
              sweep           <= '0;
              state           <= S_ZERO;
            end else begin
              state <= S_DONE;
            end
          end else if (!(ent[ptw_pkg::F_R] || ent[ptw_pkg::F_W] || ent[ptw_pkg::F_X])
                       && diff_ok) begin
            lv    <= nlv;
            slot  <= {PG_W'(diff), ptw_pkg::lvl_idx(va, int'(nlv), PAGE_SHIFT)};
            state <= S_WRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_ZERO: begin
          sweep <= sweep + 1'b1;
          if (sweep[ptw_pkg::IDX_BITS-1:0] == '1) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          if (mode == ptw_pkg::MODE_SH_MAP) begin
            ok    <= 1'b1;
            state <= S_DONE;
          end else begin
            lv    <= nlv;
            slot  <= {new_page, ptw_pkg::lvl_idx(va, int'(nlv), PAGE_SHIFT)};
            state <= S_WRD;
          end
        end
        S_SRD: state <= S_SEV;
        S_SEV: begin
          src_ent <= ent;
          slot    <= {PG_W'(root), ptw_pkg::lvl_idx(va, LEVELS, PAGE_SHIFT)};
          state   <= S_TRD;
        end
        S_TRD: state <= S_TEV;
        S_TEV: begin
          case (mode)
            ptw_pkg::MODE_SH_QUERY: begin
              ok    <= ent[ptw_pkg::F_V];
              state <= S_DONE;
            end
            ptw_pkg::MODE_SH_MAP: begin
              if (ent[ptw_pkg::F_V]) begin
                ok    <= 1'b1;
                state <= S_DONE;
              end else if (pool_ok) begin
                new_page        <= PG_W'(pool_sum);
                pages_allocated <= pages_allocated + 1'b1;
                sweep           <= '0;
                state           <= S_ZERO;
              end else begin
                state <= S_DONE;
              end
            end
            ptw_pkg::MODE_SH_COPY: begin
              ok    <= src_ent[ptw_pkg::F_V] && !ent[ptw_pkg::F_V];
              state <= S_DONE;
            end
            default: begin
              ok    <= 1'b0;
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          // Hand the result to the output register once it is free.
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_ok   <= ok;
            out_addr <= addr;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'b0, out_addr, out_ok};

endmodule

### rtl/core/ptw_checker.sv
// Port-level checks of the page table walker, bound to its top level.
module ptw_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic [63:0]  m_tdata,
  input logic         m_tvalid,
  input logic         m_tready
);

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A failed request never reports a page address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[56:1] == 56'd0)
    else $error("address on failed request");

  // A new result appears only out of a busy state, in which no request is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a busy cycle");

endmodule

bind page_table_walk_map_unmap_unit ptw_checker u_ptw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

### tb/page_table_walk_map_unmap_unit_chk.sv
// Checker for the page table walker: predicts each result and compares it.
module page_table_walk_map_unmap_unit_chk
  import ptw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [127:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  m_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [43:0]  cfg_data,
  output int           fail_count,
  output int           walks_pending,
  output int           ok_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = TABLE_PAGES_DEF;
  localparam int NLVL   = LEVELS_DEF;
  localparam int PSHIFT = PAGE_SHIFT_DEF;

  typedef struct packed {
    logic            ok;
    logic [PA_W-1:0] page_address;
  } walk_result_t;

  // Mirror of the entry RAM, the pool counter and the two registers.
  logic [ENTRY_W-1:0] shadow_table [NPAGES*PAGE_ENTRIES];
  int unsigned        pool_used;
  logic [PPN_W-1:0]   base_ppn;
  logic [6:0]         pool_start;
  walk_result_t       expected_results[$];

  function automatic int unsigned va_index(logic [VA_W-1:0] va, int unsigned lv);
    logic [VA_W-1:0] sh;
    sh = va >> (IDX_BITS * lv + PSHIFT);
    return sh[IDX_BITS-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] pointer_entry(int unsigned pg);
    logic [PPN_W-1:0] ppn;
    ppn = base_ppn + PPN_W'(pg);
    return {ppn, 6'b000001};
  endfunction

  // Bump allocator; a new page is zeroed before use.
  function automatic bit pool_grab(output int unsigned pg);
    int unsigned p;
    p = pool_start + pool_used;
    pg = 0;
    if (pool_used >= 127 || p >= NPAGES) return 0;
    for (int i = 0; i < PAGE_ENTRIES; i++) shadow_table[p*PAGE_ENTRIES+i] = '0;
    pool_used++;
    pg = p;
    return 1;
  endfunction

  // Walk down to the leaf slot, allocating missing tables when asked.
  function automatic bit find_leaf(int unsigned root, logic [VA_W-1:0] va, bit alloc,
                                   output int unsigned slot);
    int unsigned pg, s, np;
    logic [ENTRY_W-1:0] e;
    logic [PPN_W-1:0] rel;
    pg = root;
    slot = 0;
    if (pg >= NPAGES) return 0;
    for (int lv = NLVL; lv > 0; lv--) begin
      s = pg * PAGE_ENTRIES + va_index(va, lv);
      e = shadow_table[s];
      if (!e[F_V]) begin
        if (!alloc || !pool_grab(np)) return 0;
        shadow_table[s] = pointer_entry(np);
        pg = np;
      end else begin
        if (e[F_R] || e[F_W] || e[F_X]) return 0;
        rel = e[ENTRY_W-1:PPN_POS] - base_ppn;
        if (rel >= NPAGES) return 0;
        pg = rel;
      end
    end
    slot = pg * PAGE_ENTRIES + va_index(va, 0);
    return 1;
  endfunction

  // Apply one request to the mirror and work out its result.
  function automatic walk_result_t predict_walk(logic [2:0] mode, logic [127:0] d);
    walk_result_t r;
    int unsigned root, src, top, slot, np, ds, ss;
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pa;
    logic [ENTRY_W-1:0] leaf;
    root = d[5:0];
    src  = d[11:6];
    va   = d[59:12];
    pa   = d[115:60];
    top  = va_index(va, NLVL);
    r = '0;
    case (mode)
      MODE_TRANSLATE: begin
        if (find_leaf(root, va, 0, slot) && shadow_table[slot][F_V]) begin
          r.ok = 1;
          r.page_address = PA_W'({shadow_table[slot][ENTRY_W-1:PPN_POS], 12'h000});
        end
      end
      MODE_MAP: begin
        if (find_leaf(root, va, d[116], slot) && !shadow_table[slot][F_V]) begin
          leaf = {pa[PA_W-1:PSHIFT], d[121], d[120], d[119], d[118], d[117], 1'b1};
          shadow_table[slot] = leaf;
          r.ok = 1;
        end
      end
      MODE_UNMAP: begin
        if (find_leaf(root, va, 0, slot) && shadow_table[slot][F_V]) begin
          shadow_table[slot] = '0;
          r.ok = 1;
        end
      end
      MODE_SH_MAP: begin
        ds = root * PAGE_ENTRIES + top;
        if (shadow_table[ds][F_V]) r.ok = 1;
        else if (pool_grab(np)) begin
          shadow_table[ds] = pointer_entry(np);
          r.ok = 1;
        end
      end
      MODE_SH_QUERY: r.ok = shadow_table[root * PAGE_ENTRIES + top][F_V];
      MODE_SH_COPY: begin
        ds = root * PAGE_ENTRIES + top;
        ss = src * PAGE_ENTRIES + top;
        if (shadow_table[ss][F_V] && !shadow_table[ds][F_V]) begin
          shadow_table[ds] = shadow_table[ss];
          r.ok = 1;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign walks_pending = expected_results.size();

  always @(posedge clk) begin
    walk_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NPAGES*PAGE_ENTRIES; i++) shadow_table[i] = '0;
      pool_used = 0;
      base_ppn = '0;
      pool_start = 7'd1;
      expected_results.delete();
      fail_count <= 0;
      ok_count <= 0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        if (cfg_index == CFG_STORE_BASE) base_ppn = cfg_data;
        else pool_start = cfg_data[6:0];
      end
      // Request transaction: predict right away, the block serves one at a time.
      if (s_tvalid && s_tready) expected_results.push_back(predict_walk(s_tuser, s_tdata));
      // Result transaction.
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tdata[0] !== exp_r.ok || m_tdata[56:1] !== exp_r.page_address) begin
            $display("%0t: mismatch expected ok=%0b addr=%h actual ok=%0b addr=%h", $time,
                     exp_r.ok, exp_r.page_address, m_tdata[0], m_tdata[56:1]);
            fail_count <= fail_count + 1;
          end
          if (exp_r.ok) ok_count <= ok_count + 1;
        end
      end
    end
  end
endmodule

### tb/page_table_walk_map_unmap_unit_tb.sv
// Testbench top of the page table walker: stimulus, flow control and verdict.
module page_table_walk_map_unmap_unit_tb;
  import ptw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [43:0] BASE_MAX = 44'hFFF_FFFF_FFFF;

  logic         clk, rst;
  logic [127:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         s_tvalid, s_tready;
  logic [63:0]  m_tdata;
  logic         m_tvalid, m_tready;
  logic         cfg_we, cfg_index;
  logic [43:0]  cfg_data;
  int           fail_count, walks_pending, ok_count;
  int           requests_sent, results_seen;

  page_table_walk_map_unmap_unit uut (.*);
  page_table_walk_map_unmap_unit_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("page_table_walk_map_unmap_unit regression: fail");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    int n;
    m_tready = 0;
    results_seen = 0;
    @(negedge rst);
    forever begin
      n = (results_seen == 150) ? 400 : $urandom_range(0, 8);
      if (results_seen % 60 > 40) n = 0;
      if (n > 0) begin
        m_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
    end
  end

  // Offer one request and wait for its transaction.
  task automatic send_walk(logic [2:0] mode, logic [5:0] root, logic [5:0] src,
                           logic [47:0] va, logic [55:0] pa, logic [5:0] flags);
    int gap;
    gap = (requests_sent % 50 > 35) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= mode;
    s_tdata  <= {6'b0, flags, pa, va, src, root};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  task automatic write_reg(logic idx, logic [43:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk); while (walks_pending != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_table();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
  endfunction

  // Virtual addresses mostly reuse a few indexes per level so walks hit.
  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    va = 48'({$urandom, $urandom});
    if ($urandom_range(0, 7) != 0) begin
      va[38:30] = ($urandom_range(0, 3) == 0) ? 9'h1FF : 9'($urandom_range(0, 2));
      va[29:21] = 9'($urandom_range(0, 2));
      va[20:12] = ($urandom_range(0, 3) == 0) ? 9'h1FF : 9'($urandom_range(0, 3));
    end
    return va;
  endfunction

  task automatic random_walks(int count);
    logic [2:0] mode;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) mode = MODE_MAP;
      else if (r < 55) mode = MODE_TRANSLATE;
      else if (r < 67) mode = MODE_UNMAP;
      else if (r < 76) mode = MODE_SH_MAP;
      else if (r < 86) mode = MODE_SH_QUERY;
      else if (r < 96) mode = MODE_SH_COPY;
      else mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      send_walk(mode, pick_table(), pick_table(), pick_va(),
                56'({$urandom, $urandom}), 6'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 0;
    cfg_index = CFG_STORE_BASE;
    cfg_data = '0;
    requests_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    write_reg(CFG_STORE_BASE, 44'd0);
    write_reg(CFG_POOL_FIRST, 44'd1);

    // Directed: misses, allocation, double map, unmap, shallow ops, spare modes.
    send_walk(MODE_TRANSLATE, 6'd0, 6'd0, 48'h0, 56'h0, 6'h00);
    send_walk(MODE_MAP, 6'd0, 6'd0, 48'h0, 56'hFF_FFFF_FFFF_FFFF, 6'h3E);
    send_walk(MODE_MAP, 6'd0, 6'd0, 48'h0, 56'hFF_FFFF_FFFF_FFFF, 6'h3F);
    send_walk(MODE_TRANSLATE, 6'd0, 6'd0, 48'h0, 56'h0, 6'h00);
    send_walk(MODE_MAP, 6'd0, 6'd0, 48'h0, 56'h12_3456_789A_B000, 6'h01);
    send_walk(MODE_MAP, 6'd0, 6'd0, 48'hFFFF_FFFF_FFFF, 56'h0, 6'h01);
    send_walk(MODE_TRANSLATE, 6'd0, 6'd0, 48'hFFFF_FFFF_FFFF, 56'h0, 6'h00);
    send_walk(MODE_UNMAP, 6'd0, 6'd0, 48'h0, 56'h0, 6'h00);
    send_walk(MODE_UNMAP, 6'd0, 6'd0, 48'h0, 56'h0, 6'h00);
    send_walk(MODE_TRANSLATE, 6'd0, 6'd0, 48'h0, 56'h0, 6'h00);
    send_walk(MODE_SH_QUERY, 6'd3, 6'd0, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SH_MAP, 6'd3, 6'd0, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SH_MAP, 6'd3, 6'd0, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SH_QUERY, 6'd3, 6'd0, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SH_COPY, 6'd63, 6'd3, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SH_COPY, 6'd63, 6'd3, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SH_COPY, 6'd4, 6'd5, 48'h40_0000_0000, 56'h0, 6'h00);
    send_walk(MODE_SPARE_LO, 6'd0, 6'd0, 48'h0, 56'h0, 6'h3F);
    send_walk(MODE_SPARE_HI, 6'd0, 6'd0, 48'h0, 56'h0, 6'h3F);
    // The pool's first page used as a root, so its entries are walked one level too high.
    send_walk(MODE_MAP, 6'd1, 6'd0, 48'h0, 56'h5000, 6'h0F);
    send_walk(MODE_TRANSLATE, 6'd1, 6'd0, 48'h0, 56'h0, 6'h00);
    random_walks(140);
    drain();

    // Largest base and pool from page zero.
    write_reg(CFG_STORE_BASE, BASE_MAX);
    write_reg(CFG_POOL_FIRST, 44'd0);
    random_walks(140);
    drain();

    // Random base and a pool that is empty from the start.
    write_reg(CFG_STORE_BASE, 44'({$urandom, $urandom}));
    write_reg(CFG_POOL_FIRST, 44'd64);
    random_walks(130);
    drain();

    // Back to base zero with a pool that starts at a random page.
    write_reg(CFG_STORE_BASE, 44'd0);
    write_reg(CFG_POOL_FIRST, 44'($urandom_range(0, 64)));
    random_walks(140);
    drain();

    $display("Sent %0d requests over four register settings, %0d results with ok set.",
             requests_sent, ok_count);
    if (fail_count == 0) begin
      $display("page_table_walk_map_unmap_unit regression: pass");
    end else begin
      $display("page_table_walk_map_unmap_unit regression: fail");
    end
    $finish;
  end
endmodule
